[rtl/core/tbcs_pkg.sv]
// Shared types and constants of the threshold, blur and colorize stream.
`timescale 1ns / 1ps

package tbcs_pkg;

  localparam int PIX_W      = 8;
  localparam int DIM_W      = 11;
  localparam int THR_W      = 8;
  localparam int COEF_W     = 16;
  localparam int POS_W      = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int SUM4_W     = PIX_W + 2;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = COEF_W + SUM4_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int MIN_DIM    = 3;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

  localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH  = 11'd640;
  localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT = 11'd480;
  localparam logic [THR_W-1:0]  RST_LOW_THR      = 8'd90;
  localparam logic [THR_W-1:0]  RST_HIGH_THR     = 8'd170;
  localparam logic [COEF_W-1:0] RST_COEF_CORNER  = 16'd6056;
  localparam logic [COEF_W-1:0] RST_COEF_SIDE    = 16'd7812;
  localparam logic [COEF_W-1:0] RST_COEF_CENTER  = 16'd10079;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_LOW_THR      = 3'd2,
    REG_HIGH_THR     = 3'd3,
    REG_COEF_CORNER  = 3'd4,
    REG_COEF_SIDE    = 3'd5,
    REG_COEF_CENTER  = 3'd6
  } cfg_reg_t;

  // One line-store word: the two previous rows at one column.
  typedef struct packed {
    logic [PIX_W-1:0] above2;
    logic [PIX_W-1:0] above1;
  } tbcs_line_t;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } tbcs_meta_t;

  typedef struct packed {
    logic [SUM4_W-1:0] corners;
    logic [SUM4_W-1:0] edges;
    logic [PIX_W-1:0]  center;
  } tbcs_taps_t;

  typedef struct packed {
    logic [COEF_W-1:0] corner;
    logic [COEF_W-1:0] side;
    logic [COEF_W-1:0] center;
  } tbcs_coef_t;

endpackage

[rtl/core/tbcs_ram.sv]
// Generic simple dual-port RAM with a registered read port.
`timescale 1ns / 1ps

module tbcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/tbcs_scan.sv]
// Raster position counters, contrast snap and first pipeline stage.
`timescale 1ns / 1ps

module tbcs_scan import tbcs_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [PIX_W-1:0]             luma,
  input  logic [DIM_W-1:0]             frame_width,
  input  logic [DIM_W-1:0]             frame_height,
  input  logic [THR_W-1:0]             low_thr,
  input  logic [THR_W-1:0]             high_thr,
  output logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  output logic [$clog2(MAX_WIDTH)-1:0] s1_addr,
  output logic [PIX_W-1:0]             s1_pix,
  output logic                         s1_emit,
  output tbcs_meta_t                   s1_meta
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = (($clog2(MAX_WIDTH + 1) > DIM_W) ? $clog2(MAX_WIDTH + 1) : DIM_W) + 1;
  localparam int HW = (($clog2(MAX_HEIGHT + 1) > DIM_W) ? $clog2(MAX_HEIGHT + 1) : DIM_W) + 1;

  logic [CW-1:0] col_count, col_count_next;
  logic [RW-1:0] row_count, row_count_next;
  logic [WW-1:0] w, fw_ext, col_ext, c_ext, c_inc;
  logic [HW-1:0] h, fh_ext, row_ext, r_pre, r_ext, r_inc;
  logic          interior;
  logic [PIX_W-1:0] pix;

  always_comb begin
    fw_ext = WW'(frame_width);
    fh_ext = HW'(frame_height);
    if (fw_ext < WW'(MIN_DIM)) begin
      w = WW'(MIN_DIM);
    end else if (fw_ext > WW'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = fw_ext;
    end
    if (fh_ext < HW'(MIN_DIM)) begin
      h = HW'(MIN_DIM);
    end else if (fh_ext > HW'(MAX_HEIGHT)) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = fh_ext;
    end

    // A geometry change can leave the counters beyond the new frame size.
    col_ext = WW'(col_count);
    row_ext = HW'(row_count);
    if (col_ext >= w) begin
      c_ext = '0;
      r_pre = row_ext + HW'(1);
    end else begin
      c_ext = col_ext;
      r_pre = row_ext;
    end
    r_ext = (r_pre >= h) ? '0 : r_pre;

    interior = (r_ext >= HW'(1)) && (r_ext + HW'(2) <= h) &&
               (c_ext >= WW'(1)) && (c_ext + WW'(2) <= w);
    pix = luma;
    if (interior) begin
      if (pix < low_thr) begin
        pix = '0;
      end
      if (pix > high_thr) begin
        pix = PIX_MAX;
      end
    end

    c_inc = c_ext + WW'(1);
    r_inc = r_ext + HW'(1);
    if (c_inc >= w) begin
      col_count_next = '0;
      row_count_next = (r_inc >= h) ? '0 : RW'(r_inc);
    end else begin
      col_count_next = CW'(c_inc);
      row_count_next = RW'(r_ext);
    end
  end

  assign rd_addr = CW'(c_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr      <= CW'(c_ext);
      s1_pix       <= pix;
      s1_emit      <= (r_ext >= HW'(2)) && (c_ext >= WW'(2));
      s1_meta.row  <= POS_W'(r_ext - HW'(1));
      s1_meta.col  <= POS_W'(c_ext - WW'(1));
      s1_meta.last <= (r_ext == h - HW'(1)) && (c_ext == w - WW'(1));
    end
  end

  a_col_in_frame: assert property (@(posedge clk) disable iff (rst)
    accept |=> (WW'(col_count) < $past(w)))
    else $error("column counter left the frame after a transaction");

  a_row_in_frame: assert property (@(posedge clk) disable iff (rst)
    accept |=> (HW'(row_count) < $past(h)))
    else $error("row counter left the frame after a transaction");

endmodule

[rtl/core/tbcs_window.sv]
// 3x3 neighborhood window, line-store write-back and tap sums.
`timescale 1ns / 1ps

module tbcs_window import tbcs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  tbcs_line_t       rd_line,
  input  logic [PIX_W-1:0] pix,
  input  tbcs_meta_t       meta_in,
  output tbcs_line_t       wr_line,
  output tbcs_taps_t       taps,
  output tbcs_meta_t       meta_out
);

  // Only the middle and right columns are kept; the left column of the
  // shifted window is the old middle column.
  logic [PIX_W-1:0] win_mid   [3];
  logic [PIX_W-1:0] win_right [3];

  assign wr_line.above2 = rd_line.above1;
  assign wr_line.above1 = pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        win_mid[k]   <= '0;
        win_right[k] <= '0;
      end
    end else if (advance) begin
      for (int k = 0; k < 3; k++) begin
        win_mid[k] <= win_right[k];
      end
      win_right[0] <= rd_line.above2;
      win_right[1] <= rd_line.above1;
      win_right[2] <= pix;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      taps.corners <= SUM4_W'(win_mid[0]) + SUM4_W'(rd_line.above2) +
                      SUM4_W'(win_mid[2]) + SUM4_W'(pix);
      taps.edges   <= SUM4_W'(win_right[0]) + SUM4_W'(win_mid[1]) +
                      SUM4_W'(rd_line.above1) + SUM4_W'(win_right[2]);
      taps.center  <= win_right[1];
      meta_out     <= meta_in;
    end
  end

endmodule

[rtl/core/tbcs_mac.sv]
// Weighted sum, saturation and false coloring with the output register.
`timescale 1ns / 1ps

module tbcs_mac import tbcs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  tbcs_coef_t       coef,
  input  logic             in_valid,
  output logic             in_ready,
  input  tbcs_taps_t       taps,
  input  tbcs_meta_t       meta_in,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PIX_W-1:0] blurred,
  output logic [PIX_W-1:0] out_red,
  output logic [PIX_W-1:0] out_green,
  output logic [PIX_W-1:0] out_blue,
  output tbcs_meta_t       meta_out
);

  logic              v3;
  logic              out_en;
  logic [PROD_W-1:0] p_corner, p_side, p_center;
  tbcs_meta_t        meta3;
  logic [ACC_W-1:0]  acc;
  logic [ACC_W-FRAC_W-1:0] quot;
  logic [PIX_W-1:0]  b;

  assign out_en   = !out_valid || out_ready;
  assign in_ready = !v3 || out_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        v3 <= in_valid;
      end
      if (out_en) begin
        out_valid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      p_corner <= PROD_W'(coef.corner) * PROD_W'(taps.corners);
      p_side   <= PROD_W'(coef.side) * PROD_W'(taps.edges);
      p_center <= PROD_W'(coef.center) * PROD_W'(taps.center);
      meta3    <= meta_in;
    end
  end

  always_comb begin
    acc  = ACC_W'(p_corner) + ACC_W'(p_side) + ACC_W'(p_center);
    quot = acc[ACC_W-1:FRAC_W];
    b    = (quot > (ACC_W-FRAC_W)'(PIX_MAX)) ? PIX_MAX : quot[PIX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (out_en && v3) begin
      blurred   <= b;
      out_red   <= {b[PIX_W-2:0], 1'b0};
      out_green <= (b == '0) ? PIX_MAX : {1'b0, b[PIX_W-1:1]};
      out_blue  <= b;
      meta_out  <= meta3;
    end
  end

endmodule

[rtl/core/threshold_blur_colorize_stream.sv]
// Top level: contrast snap, 3x3 weighted blur and false coloring of a pixel stream.
`timescale 1ns / 1ps
// A result passes stage 1, tap sums, products and output register after the accept
// of the lower-right neighbor of its center pixel. One pixel per clock unless
// stalled, set by the single read and single write port of the line-store RAM.
// Reset (synchronous, active high) restores the register defaults, clears the
// raster counters, the window and all valid flags; the line store is not cleared
// and has no clearing pass, so the block accepts pixels right after reset.

module threshold_blur_colorize_stream import tbcs_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  // Pixel input channel.
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIX_W-1:0]      luma_in,
  // Result output channel.
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIX_W-1:0]      blurred,
  output logic [PIX_W-1:0]      out_red,
  output logic [PIX_W-1:0]      out_green,
  output logic [PIX_W-1:0]      out_blue,
  output logic [POS_W-1:0]      out_row,
  output logic [POS_W-1:0]      out_col,
  output logic                  last_of_frame,
  // Configuration write channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);

  // Configuration registers. The port never stalls a write transaction.
  logic [DIM_W-1:0] frame_width, frame_height;
  logic [THR_W-1:0] low_thr, high_thr;
  tbcs_coef_t       coef;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
      low_thr      <= RST_LOW_THR;
      high_thr     <= RST_HIGH_THR;
      coef.corner  <= RST_COEF_CORNER;
      coef.side    <= RST_COEF_SIDE;
      coef.center  <= RST_COEF_CENTER;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[DIM_W-1:0];
        REG_LOW_THR:      low_thr      <= cfg_data[THR_W-1:0];
        REG_HIGH_THR:     high_thr     <= cfg_data[THR_W-1:0];
        REG_COEF_CORNER:  coef.corner  <= cfg_data;
        REG_COEF_SIDE:    coef.side    <= cfg_data;
        REG_COEF_CENTER:  coef.center  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline control. Stage 1 holds an accepted pixel while its line-store
  // read is in flight; stage 2 holds the tap sums of an interior pixel;
  // the multiply stage and the output register live in the MAC. Each stage
  // moves on when the next one is empty or moving, so bubbles close up and a
  // waiting result does not block input until the pipeline is full.
  logic       v1, v2;
  logic       mac_ready;
  logic       en2, s1_go, in_accept;

  assign en2       = !v2 || mac_ready;
  assign s1_go     = v1 && en2;
  assign in_ready  = !v1 || en2;
  assign in_accept = in_valid && in_ready;

  logic [CW-1:0] rd_addr, s1_addr;
  logic [PIX_W-1:0] s1_pix;
  logic          s1_emit;
  tbcs_meta_t    s1_meta, s2_meta, out_meta;
  tbcs_line_t    rd_line, wr_line;
  tbcs_taps_t    taps;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (in_ready) begin
        v1 <= in_valid;
      end
      // Border pixels still shift the window but carry no result onward.
      if (en2) begin
        v2 <= v1 && s1_emit;
      end
    end
  end

  tbcs_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .accept       (in_accept),
    .luma         (luma_in),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .low_thr      (low_thr),
    .high_thr     (high_thr),
    .rd_addr      (rd_addr),
    .s1_addr      (s1_addr),
    .s1_pix       (s1_pix),
    .s1_emit      (s1_emit),
    .s1_meta      (s1_meta)
  );

  // Line store: one word per column holding the two previous rows. The read
  // is issued with the accept and the updated word is written back when the
  // pixel leaves stage 1. Consecutive pixels always sit at different columns,
  // and a column recurs at least three pixels later, so a read never meets
  // a pending write to the same word and no forwarding is needed. The read
  // data register only loads on an accept, so it holds while stage 1 stalls.
  tbcs_ram #(
    .WIDTH ($bits(tbcs_line_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_addr),
    .wdata (wr_line),
    .re    (in_accept),
    .raddr (rd_addr),
    .rdata (rd_line)
  );

  tbcs_window u_window (
    .clk      (clk),
    .rst      (rst),
    .advance  (s1_go),
    .rd_line  (rd_line),
    .pix      (s1_pix),
    .meta_in  (s1_meta),
    .wr_line  (wr_line),
    .taps     (taps),
    .meta_out (s2_meta)
  );

  tbcs_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .coef      (coef),
    .in_valid  (v2),
    .in_ready  (mac_ready),
    .taps      (taps),
    .meta_in   (s2_meta),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .blurred   (blurred),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .meta_out  (out_meta)
  );

  assign out_row       = out_meta.row;
  assign out_col       = out_meta.col;
  assign last_of_frame = out_meta.last;

  a_no_same_word: assert property (@(posedge clk) disable iff (rst)
    (s1_go && in_accept) |-> (s1_addr != rd_addr))
    else $error("line-store read and write hit the same column in one cycle");

endmodule
